FILE: hdl/rvid_pkg.sv
// Package: operation codes and shared types of the RV32 instruction decoder.
package rvid_pkg;

    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_FENCE  = 7'h0F;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;
    localparam logic [6:0] OPC_AMO    = 7'h2F;

    localparam logic [11:0] SYS_ECALL  = 12'h000;
    localparam logic [11:0] SYS_EBREAK = 12'h001;
    localparam logic [11:0] SYS_URET   = 12'h002;
    localparam logic [11:0] SYS_SRET   = 12'h102;
    localparam logic [11:0] SYS_WFI    = 12'h105;
    localparam logic [11:0] SYS_MRET   = 12'h302;

    typedef enum logic [7:0] {
        K_UNK, K_ILL,
        K_LUI, K_AUIPC, K_JAL, K_JALR, K_BEQ, K_BNE, K_BLT, K_BGE, K_BLTU, K_BGEU,
        K_LB, K_LH, K_LW, K_LBU, K_LHU, K_SB, K_SH, K_SW,
        K_ADDI, K_SLTI, K_SLTIU, K_XORI, K_ORI, K_ANDI, K_SLLI, K_SRLI, K_SRAI,
        K_ADD, K_SUB, K_SLL, K_SLT, K_SLTU, K_XOR, K_SRL, K_SRA, K_OR, K_AND,
        K_FENCE, K_FENCEI,
        K_ECALL, K_EBREAK, K_WFI, K_MRET, K_SRET, K_URET,
        K_CSRRW, K_CSRRS, K_CSRRC, K_CSRRWI, K_CSRRSI, K_CSRRCI,
        K_MUL, K_MULH, K_MULHSU, K_MULHU, K_DIV, K_DIVU, K_REM, K_REMU,
        K_SH1ADD, K_SH2ADD, K_SH3ADD,
        K_XNOR, K_ORN, K_ANDN, K_MIN, K_MINU, K_MAX, K_MAXU, K_PACK, K_PACKH,
        K_ROL, K_ROR, K_CLZ, K_CTZ, K_CPOP, K_SEXTB, K_SEXTH, K_REV8, K_ORCB,
        K_ZEXTH, K_RORI,
        K_CLMUL, K_CLMULR, K_CLMULH,
        K_BCLR, K_BEXT, K_BINV, K_BSET, K_BEXTI, K_BINVI, K_BSETI, K_BCLRI,
        K_LR, K_SC, K_AMOSWAP, K_AMOADD, K_AMOXOR, K_AMOAND, K_AMOOR, K_AMOMIN,
        K_AMOMAX, K_AMOMINU, K_AMOMAXU,
        K_CADDI4SPN, K_CFLD, K_CLW, K_CFLW, K_CFSD, K_CSW, K_CFSW,
        K_CNOP, K_CADDI, K_CJAL, K_CLI, K_CADDI16SP, K_CLUI, K_CSRLI, K_CSRAI,
        K_CANDI, K_CSUB, K_CXOR, K_COR, K_CAND, K_CJ, K_CBEQZ, K_CBNEZ,
        K_CSLLI, K_CFLDSP, K_CLWSP, K_CFLWSP, K_CJR, K_CMV, K_CEBREAK, K_CJALR,
        K_CADD, K_CFSDSP, K_CSWSP, K_CFSWSP
    } t_op;

    // Decode result carried between stages.
    typedef struct packed {
        t_op         op;
        logic        comp;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
        logic [11:0] csr;
        logic        has_tgt;
        logic        aq;
        logic        rl;
        logic        dw;
    } t_dec;

endpackage

FILE: hdl/rv32_instruction_decoder_core.sv
// Top level: three-stage pipelined RV32IMAC and Zb* instruction decoder.
// Throughput: one item per cycle while no stall holds the stages; stage 1 registers
// the word, stage 2 the decode (the opcode tables), stage 3 the pc-relative target add.
// A stall holds every stage whose successor is occupied and itself held.
// Reset (synchronous, active low) empties all stages; payload registers are not reset.
module rv32_instruction_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_instr_word,
    input  logic [31:0] i_pc,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_op_id,
    output logic        o_is_compressed,
    output logic [4:0]  o_rd,
    output logic [4:0]  o_rs1,
    output logic [4:0]  o_rs2,
    output logic signed [31:0] o_imm,
    output logic [11:0] o_csr_addr,
    output logic [31:0] o_target,
    output logic        o_acquire,
    output logic        o_release_res,
    output logic        o_double_width
);

    // Each stage moves when the next one is empty or moving itself.
    logic r_v1, r_v2, r_v3;
    logic adv1, adv2, adv3;
    logic [31:0] r_w1, r_pc1, r_pc2;
    rvid_pkg::t_dec r_d2, r_d3;
    rvid_pkg::t_dec n_d2;
    logic [31:0] r_tgt3;

    assign adv3 = !r_v3 || !i_stall;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign o_stall = !adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_w1  <= i_instr_word;
            r_pc1 <= i_pc;
        end
        if (adv2) begin
            r_d2  <= n_d2;
            r_pc2 <= r_pc1;
        end
        if (adv3) begin
            r_d3   <= r_d2;
            r_tgt3 <= r_d2.has_tgt ? r_pc2 + r_d2.imm : 32'd0;
        end
    end

    // Stage 2: the decode proper.
    always_comb begin
        logic [31:0] w;
        logic [15:0] h;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [4:0]  rd, r1, r2, r5, s5, ph, pl;
        logic [31:0] i12, c6, u6, jo, bo, wo, v;
        rvid_pkg::t_op o;
        w  = r_w1;
        h  = r_w1[15:0];
        f3 = w[14:12];
        f7 = w[31:25];
        rd = w[11:7];
        r1 = w[19:15];
        r2 = w[24:20];
        i12 = {{20{w[31]}}, w[31:20]};
        r5 = h[11:7];
        s5 = h[6:2];
        ph = {2'b01, h[9:7]};
        pl = {2'b01, h[4:2]};
        c6 = {{26{h[12]}}, h[12], h[6:2]};
        u6 = {26'd0, h[12], h[6:2]};
        jo = {{21{h[12]}}, h[8], h[10:9], h[6], h[7], h[2], h[11], h[5:3], 1'b0};
        bo = {{24{h[12]}}, h[6:5], h[2], h[11:10], h[4:3], 1'b0};
        wo = {25'd0, h[5], h[12:10], h[6], 2'b00};
        v  = 32'd0;
        o  = rvid_pkg::K_UNK;
        n_d2 = '0;
        if (w[1:0] != 2'b11) begin
            n_d2.comp = 1'b1;
            unique case ({h[1:0], h[15:13]})
                5'b00000: begin
                    v = {22'd0, h[10:7], h[12:11], h[5], h[6], 2'b00};
                    if (v == 32'd0) n_d2.op = rvid_pkg::K_ILL;
                    else begin
                        n_d2.op = rvid_pkg::K_CADDI4SPN;
                        n_d2.rd = pl; n_d2.rs1 = 5'd2; n_d2.imm = v;
                    end
                end
                5'b00001: n_d2.op = rvid_pkg::K_CFLD;
                5'b00010: begin
                    n_d2.op = rvid_pkg::K_CLW; n_d2.rd = pl; n_d2.rs1 = ph; n_d2.imm = wo;
                end
                5'b00011: n_d2.op = rvid_pkg::K_CFLW;
                5'b00101: n_d2.op = rvid_pkg::K_CFSD;
                5'b00110: begin
                    n_d2.op = rvid_pkg::K_CSW; n_d2.rs2 = pl; n_d2.rs1 = ph; n_d2.imm = wo;
                end
                5'b00111: n_d2.op = rvid_pkg::K_CFSW;
                5'b01000: begin
                    if (r5 == 5'd0) begin
                        n_d2.op = (c6 == 32'd0) ? rvid_pkg::K_CNOP : rvid_pkg::K_ILL;
                    end else begin
                        n_d2.op = rvid_pkg::K_CADDI; n_d2.rd = r5; n_d2.rs1 = r5;
                        n_d2.imm = c6;
                    end
                end
                5'b01001: begin
                    n_d2.op = rvid_pkg::K_CJAL; n_d2.rd = 5'd1; n_d2.imm = jo;
                    n_d2.has_tgt = 1'b1;
                end
                5'b01010: begin
                    if (r5 == 5'd0) n_d2.op = rvid_pkg::K_ILL;
                    else begin
                        n_d2.op = rvid_pkg::K_CLI; n_d2.rd = r5; n_d2.imm = c6;
                    end
                end
                5'b01011: begin
                    if (r5 == 5'd2) begin
                        v = {{23{h[12]}}, h[4:3], h[5], h[2], h[6], 4'd0};
                        if (v == 32'd0) n_d2.op = rvid_pkg::K_ILL;
                        else begin
                            n_d2.op = rvid_pkg::K_CADDI16SP; n_d2.rd = 5'd2;
                            n_d2.rs1 = 5'd2; n_d2.imm = v;
                        end
                    end else if (r5 == 5'd0 || c6 == 32'd0) begin
                        n_d2.op = rvid_pkg::K_ILL;
                    end else begin
                        n_d2.op = rvid_pkg::K_CLUI; n_d2.rd = r5;
                        n_d2.imm = {c6[19:0], 12'd0};
                    end
                end
                5'b01100: begin
                    if (h[11:10] == 2'b11) begin
                        if (!h[12]) begin
                            n_d2.op = rvid_pkg::t_op'(8'(rvid_pkg::K_CSUB) + 8'(h[6:5]));
                            n_d2.rs2 = pl; n_d2.rd = ph; n_d2.rs1 = ph;
                        end
                    end else begin
                        n_d2.op = rvid_pkg::t_op'(8'(rvid_pkg::K_CSRLI) + 8'(h[11:10]));
                        n_d2.imm = (h[11:10] == 2'b10) ? c6 : u6;
                        n_d2.rd = ph; n_d2.rs1 = ph;
                    end
                end
                5'b01101: begin
                    n_d2.op = rvid_pkg::K_CJ; n_d2.imm = jo; n_d2.has_tgt = 1'b1;
                end
                5'b01110, 5'b01111: begin
                    n_d2.op = h[13] ? rvid_pkg::K_CBNEZ : rvid_pkg::K_CBEQZ;
                    n_d2.rs1 = ph; n_d2.imm = bo; n_d2.has_tgt = 1'b1;
                end
                5'b10000: begin
                    if (r5 == 5'd0 || u6 == 32'd0) n_d2.op = rvid_pkg::K_ILL;
                    else begin
                        n_d2.op = rvid_pkg::K_CSLLI; n_d2.rd = r5; n_d2.rs1 = r5;
                        n_d2.imm = u6;
                    end
                end
                5'b10001: n_d2.op = rvid_pkg::K_CFLDSP;
                5'b10010: begin
                    if (r5 == 5'd0) n_d2.op = rvid_pkg::K_ILL;
                    else begin
                        n_d2.op = rvid_pkg::K_CLWSP; n_d2.rd = r5; n_d2.rs1 = 5'd2;
                        n_d2.imm = {24'd0, h[3:2], h[12], h[6:4], 2'b00};
                    end
                end
                5'b10011: n_d2.op = rvid_pkg::K_CFLWSP;
                5'b10100: begin
                    if (!h[12]) begin
                        if (s5 == 5'd0) begin
                            if (r5 == 5'd0) n_d2.op = rvid_pkg::K_ILL;
                            else begin
                                n_d2.op = rvid_pkg::K_CJR; n_d2.rs1 = r5;
                            end
                        end else begin
                            n_d2.op = rvid_pkg::K_CMV; n_d2.rd = r5; n_d2.rs2 = s5;
                        end
                    end else if (r5 == 5'd0 && s5 == 5'd0) begin
                        n_d2.op = rvid_pkg::K_CEBREAK;
                    end else if (s5 == 5'd0) begin
                        n_d2.op = rvid_pkg::K_CJALR; n_d2.rd = 5'd1; n_d2.rs1 = r5;
                    end else begin
                        n_d2.op = rvid_pkg::K_CADD; n_d2.rd = r5; n_d2.rs1 = r5;
                        n_d2.rs2 = s5;
                    end
                end
                5'b10101: n_d2.op = rvid_pkg::K_CFSDSP;
                5'b10110: begin
                    n_d2.op = rvid_pkg::K_CSWSP; n_d2.rs2 = s5; n_d2.rs1 = 5'd2;
                    n_d2.imm = {24'd0, h[8:7], h[12:9], 2'b00};
                end
                5'b10111: n_d2.op = rvid_pkg::K_CFSWSP;
                default: n_d2.op = rvid_pkg::K_UNK;
            endcase
        end else begin
            unique case (w[6:0])
                rvid_pkg::OPC_LUI, rvid_pkg::OPC_AUIPC: begin
                    n_d2.op = (w[6:0] == rvid_pkg::OPC_LUI) ? rvid_pkg::K_LUI
                                                            : rvid_pkg::K_AUIPC;
                    n_d2.rd = rd; n_d2.imm = {w[31:12], 12'd0};
                end
                rvid_pkg::OPC_JAL: begin
                    n_d2.op = rvid_pkg::K_JAL; n_d2.rd = rd; n_d2.has_tgt = 1'b1;
                    n_d2.imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
                end
                rvid_pkg::OPC_JALR: begin
                    n_d2.op = rvid_pkg::K_JALR; n_d2.rd = rd; n_d2.rs1 = r1;
                    n_d2.imm = i12;
                end
                rvid_pkg::OPC_BRANCH: begin
                    case (f3)
                        3'd0: o = rvid_pkg::K_BEQ;
                        3'd1: o = rvid_pkg::K_BNE;
                        3'd4: o = rvid_pkg::K_BLT;
                        3'd5: o = rvid_pkg::K_BGE;
                        3'd6: o = rvid_pkg::K_BLTU;
                        3'd7: o = rvid_pkg::K_BGEU;
                        default: o = rvid_pkg::K_UNK;
                    endcase
                    if (o != rvid_pkg::K_UNK) begin
                        n_d2.op = o; n_d2.rs1 = r1; n_d2.rs2 = r2; n_d2.has_tgt = 1'b1;
                        n_d2.imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
                    end
                end
                rvid_pkg::OPC_LOAD: begin
                    case (f3)
                        3'd0: o = rvid_pkg::K_LB;
                        3'd1: o = rvid_pkg::K_LH;
                        3'd2: o = rvid_pkg::K_LW;
                        3'd4: o = rvid_pkg::K_LBU;
                        3'd5: o = rvid_pkg::K_LHU;
                        default: o = rvid_pkg::K_UNK;
                    endcase
                    if (o != rvid_pkg::K_UNK) begin
                        n_d2.op = o; n_d2.rd = rd; n_d2.rs1 = r1; n_d2.imm = i12;
                    end
                end
                rvid_pkg::OPC_STORE: begin
                    case (f3)
                        3'd0: o = rvid_pkg::K_SB;
                        3'd1: o = rvid_pkg::K_SH;
                        3'd2: o = rvid_pkg::K_SW;
                        default: o = rvid_pkg::K_UNK;
                    endcase
                    if (o != rvid_pkg::K_UNK) begin
                        n_d2.op = o; n_d2.rs1 = r1; n_d2.rs2 = r2;
                        n_d2.imm = {{20{w[31]}}, w[31:25], w[11:7]};
                    end
                end
                rvid_pkg::OPC_OPIMM: begin
                    v = i12;
                    case (f3)
                        3'd0: o = rvid_pkg::K_ADDI;
                        3'd2: o = rvid_pkg::K_SLTI;
                        3'd3: o = rvid_pkg::K_SLTIU;
                        3'd4: o = rvid_pkg::K_XORI;
                        3'd6: o = rvid_pkg::K_ORI;
                        3'd7: o = rvid_pkg::K_ANDI;
                        3'd1: begin
                            v = {27'd0, r2};
                            if (f7 == 7'h00) o = rvid_pkg::K_SLLI;
                            else if (f7 == 7'h30) begin
                                v = 32'd0;
                                case (r2)
                                    5'd0: o = rvid_pkg::K_CLZ;
                                    5'd1: o = rvid_pkg::K_CTZ;
                                    5'd2: o = rvid_pkg::K_CPOP;
                                    5'd4: o = rvid_pkg::K_SEXTB;
                                    5'd5: o = rvid_pkg::K_SEXTH;
                                    default: o = rvid_pkg::K_UNK;
                                endcase
                            end
                            else if (f7 == 7'h24) o = rvid_pkg::K_BCLRI;
                            else if (f7 == 7'h34) o = rvid_pkg::K_BINVI;
                            else if (f7 == 7'h14) o = rvid_pkg::K_BSETI;
                        end
                        default: begin
                            v = {27'd0, r2};
                            if (f7 == 7'h00) o = rvid_pkg::K_SRLI;
                            else if (f7 == 7'h20) o = rvid_pkg::K_SRAI;
                            else if (f7 == 7'h30) o = rvid_pkg::K_RORI;
                            else if (f7 == 7'h24) o = rvid_pkg::K_BEXTI;
                            else if (f7 == 7'h14 && r2 == 5'd7) begin
                                o = rvid_pkg::K_ORCB; v = 32'd0;
                            end else if (f7 == 7'h34 && r2 == 5'h18) begin
                                o = rvid_pkg::K_REV8; v = 32'd0;
                            end
                        end
                    endcase
                    if (o != rvid_pkg::K_UNK) begin
                        n_d2.op = o; n_d2.rd = rd; n_d2.rs1 = r1; n_d2.imm = v;
                    end
                end
                rvid_pkg::OPC_OP: begin
                    case (f7)
                        7'h00: begin
                            case (f3)
                                3'd0: o = rvid_pkg::K_ADD;
                                3'd1: o = rvid_pkg::K_SLL;
                                3'd2: o = rvid_pkg::K_SLT;
                                3'd3: o = rvid_pkg::K_SLTU;
                                3'd4: o = rvid_pkg::K_XOR;
                                3'd5: o = rvid_pkg::K_SRL;
                                3'd6: o = rvid_pkg::K_OR;
                                default: o = rvid_pkg::K_AND;
                            endcase
                        end
                        7'h01: o = rvid_pkg::t_op'(8'(rvid_pkg::K_MUL) + 8'(f3));
                        7'h20: begin
                            case (f3)
                                3'd0: o = rvid_pkg::K_SUB;
                                3'd5: o = rvid_pkg::K_SRA;
                                3'd4: o = rvid_pkg::K_XNOR;
                                3'd6: o = rvid_pkg::K_ORN;
                                3'd7: o = rvid_pkg::K_ANDN;
                                default: o = rvid_pkg::K_UNK;
                            endcase
                        end
                        7'h05: begin
                            if (f3[2]) o = rvid_pkg::t_op'(8'(rvid_pkg::K_MIN) + 8'(f3[1:0]));
                            else if (f3 != 3'd0)
                                o = rvid_pkg::t_op'(8'(rvid_pkg::K_CLMUL) + 8'(f3) - 8'd1);
                        end
                        7'h04: begin
                            if (f3 == 3'd4)
                                o = (r2 == 5'd0) ? rvid_pkg::K_ZEXTH : rvid_pkg::K_PACK;
                            else if (f3 == 3'd7) o = rvid_pkg::K_PACKH;
                        end
                        7'h30: begin
                            if (f3 == 3'd1) o = rvid_pkg::K_ROL;
                            else if (f3 == 3'd5) o = rvid_pkg::K_ROR;
                        end
                        7'h10: begin
                            if (f3 == 3'd2) o = rvid_pkg::K_SH1ADD;
                            else if (f3 == 3'd4) o = rvid_pkg::K_SH2ADD;
                            else if (f3 == 3'd6) o = rvid_pkg::K_SH3ADD;
                        end
                        7'h24: begin
                            if (f3 == 3'd1) o = rvid_pkg::K_BCLR;
                            else if (f3 == 3'd5) o = rvid_pkg::K_BEXT;
                        end
                        7'h34: if (f3 == 3'd1) o = rvid_pkg::K_BINV;
                        7'h14: if (f3 == 3'd1) o = rvid_pkg::K_BSET;
                        default: o = rvid_pkg::K_UNK;
                    endcase
                    if (o != rvid_pkg::K_UNK) begin
                        n_d2.op = o; n_d2.rd = rd; n_d2.rs1 = r1; n_d2.rs2 = r2;
                    end
                end
                rvid_pkg::OPC_FENCE: begin
                    if (f3 == 3'd0) n_d2.op = rvid_pkg::K_FENCE;
                    else if (f3 == 3'd1) n_d2.op = rvid_pkg::K_FENCEI;
                end
                rvid_pkg::OPC_SYSTEM: begin
                    if (f3 == 3'd0) begin
                        case (w[31:20])
                            rvid_pkg::SYS_ECALL:  n_d2.op = rvid_pkg::K_ECALL;
                            rvid_pkg::SYS_EBREAK: n_d2.op = rvid_pkg::K_EBREAK;
                            rvid_pkg::SYS_WFI:    n_d2.op = rvid_pkg::K_WFI;
                            rvid_pkg::SYS_MRET:   n_d2.op = rvid_pkg::K_MRET;
                            rvid_pkg::SYS_SRET:   n_d2.op = rvid_pkg::K_SRET;
                            rvid_pkg::SYS_URET:   n_d2.op = rvid_pkg::K_URET;
                            default:              n_d2.op = rvid_pkg::K_UNK;
                        endcase
                    end else if (f3 != 3'd4) begin
                        n_d2.op = f3[2]
                            ? rvid_pkg::t_op'(8'(rvid_pkg::K_CSRRWI) + 8'(f3[1:0]) - 8'd1)
                            : rvid_pkg::t_op'(8'(rvid_pkg::K_CSRRW) + 8'(f3[1:0]) - 8'd1);
                        n_d2.rd = rd; n_d2.rs1 = r1; n_d2.csr = w[31:20];
                    end
                end
                rvid_pkg::OPC_AMO: begin
                    if (f3 == 3'd2 || f3 == 3'd3) begin
                        case (w[31:27])
                            5'h00: o = rvid_pkg::K_AMOADD;
                            5'h01: o = rvid_pkg::K_AMOSWAP;
                            5'h02: o = rvid_pkg::K_LR;
                            5'h03: o = rvid_pkg::K_SC;
                            5'h04: o = rvid_pkg::K_AMOXOR;
                            5'h08: o = rvid_pkg::K_AMOOR;
                            5'h0C: o = rvid_pkg::K_AMOAND;
                            5'h10: o = rvid_pkg::K_AMOMIN;
                            5'h14: o = rvid_pkg::K_AMOMAX;
                            5'h18: o = rvid_pkg::K_AMOMINU;
                            5'h1C: o = rvid_pkg::K_AMOMAXU;
                            default: o = rvid_pkg::K_UNK;
                        endcase
                    end
                    if (o != rvid_pkg::K_UNK) begin
                        n_d2.op = o; n_d2.rd = rd; n_d2.rs1 = r1;
                        n_d2.rs2 = (o == rvid_pkg::K_LR) ? 5'd0 : r2;
                        n_d2.aq = w[26]; n_d2.rl = w[25]; n_d2.dw = f3[0];
                    end
                end
                default: n_d2.op = rvid_pkg::K_UNK;
            endcase
        end
    end

    assign o_valid         = r_v3;
    assign o_op_id         = r_d3.op;
    assign o_is_compressed = r_d3.comp;
    assign o_rd            = r_d3.rd;
    assign o_rs1           = r_d3.rs1;
    assign o_rs2           = r_d3.rs2;
    assign o_imm           = r_d3.imm;
    assign o_csr_addr      = r_d3.csr;
    assign o_target        = r_tgt3;
    assign o_acquire       = r_d3.aq;
    assign o_release_res   = r_d3.rl;
    assign o_double_width  = r_d3.dw;

`ifndef NO_ASSERTIONS
    // A stalled result must not be overwritten.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && i_stall) |=> (r_v3 && $stable(r_tgt3) && $stable(r_d3)))
        else $error("stalled result changed");
    // The input is stalled only when all three stages are full.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && i_stall))
        else $error("input stalled with a free stage");
    // Only branch and jump operations carry a nonzero target.
    a_tgt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !r_d3.has_tgt) |-> (r_tgt3 == 32'd0))
        else $error("target on a non-branch");
    // Unknown and illegal words report no fields.
    a_unk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && (r_d3.op == rvid_pkg::K_UNK || r_d3.op == rvid_pkg::K_ILL))
            |-> (r_d3.rd == 5'd0 && r_d3.imm == 32'd0 && !r_d3.has_tgt))
        else $error("fields on an undecoded word");
`endif

endmodule

FILE: sim/rv32_instruction_decoder_core_tb.sv
// Self-checking testbench for the RV32 instruction decoder core.
`timescale 1ns / 100ps

module rv32_instruction_decoder_core_tb;

    localparam int CLK_HALF   = 6;
    localparam int WATCH_MAX  = 2000;
    localparam int RAND_ITEMS = 1650;

    // One decoded instruction as the outputs present it.
    typedef struct packed {
        logic [7:0]  op;
        logic        comp;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
        logic [11:0] csr;
        logic [31:0] tgt;
        logic        aq;
        logic        rl;
        logic        dw;
    } t_decode;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_instr_word;
    logic [31:0] i_pc;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_op_id;
    logic        o_is_compressed;
    logic [4:0]  o_rd;
    logic [4:0]  o_rs1;
    logic [4:0]  o_rs2;
    logic signed [31:0] o_imm;
    logic [11:0] o_csr_addr;
    logic [31:0] o_target;
    logic        o_acquire;
    logic        o_release_res;
    logic        o_double_width;

    t_decode     decode_queue[$];
    int          error_count;
    int          sent_count;
    int          checked_count;
    int          idle_cycles;
    int          compressed_sent;

    rv32_instruction_decoder_core u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Sign extension of the low n bits of a value.
    function automatic logic [31:0] sext(input logic [31:0] v, input int n);
        logic [31:0] m;
        m = 32'h1 << (n - 1);
        v = v & ((m << 1) - 32'h1);
        return (v ^ m) - m;
    endfunction

    // Register and shift decode for the OP major opcode.
    function automatic rvid_pkg::t_op reg_op(input logic [6:0] f7, input logic [2:0] f3,
                                             input logic [4:0] r2);
        case (f7)
            7'h00: begin
                case (f3)
                    3'd0: return rvid_pkg::K_ADD;
                    3'd1: return rvid_pkg::K_SLL;
                    3'd2: return rvid_pkg::K_SLT;
                    3'd3: return rvid_pkg::K_SLTU;
                    3'd4: return rvid_pkg::K_XOR;
                    3'd5: return rvid_pkg::K_SRL;
                    3'd6: return rvid_pkg::K_OR;
                    default: return rvid_pkg::K_AND;
                endcase
            end
            7'h01: return rvid_pkg::t_op'(rvid_pkg::K_MUL + f3);
            7'h20: begin
                case (f3)
                    3'd0: return rvid_pkg::K_SUB;
                    3'd5: return rvid_pkg::K_SRA;
                    3'd4: return rvid_pkg::K_XNOR;
                    3'd6: return rvid_pkg::K_ORN;
                    3'd7: return rvid_pkg::K_ANDN;
                    default: return rvid_pkg::K_UNK;
                endcase
            end
            7'h05: begin
                if (f3 >= 4) return rvid_pkg::t_op'(rvid_pkg::K_MIN + (f3 - 4));
                if (f3 >= 1) return rvid_pkg::t_op'(rvid_pkg::K_CLMUL + (f3 - 1));
                return rvid_pkg::K_UNK;
            end
            7'h04: begin
                if (f3 == 4) return (r2 == 0) ? rvid_pkg::K_ZEXTH : rvid_pkg::K_PACK;
                return (f3 == 7) ? rvid_pkg::K_PACKH : rvid_pkg::K_UNK;
            end
            7'h30: return (f3 == 1) ? rvid_pkg::K_ROL
                                    : ((f3 == 5) ? rvid_pkg::K_ROR : rvid_pkg::K_UNK);
            7'h10: begin
                if (f3 == 2) return rvid_pkg::K_SH1ADD;
                if (f3 == 4) return rvid_pkg::K_SH2ADD;
                if (f3 == 6) return rvid_pkg::K_SH3ADD;
                return rvid_pkg::K_UNK;
            end
            7'h24: return (f3 == 1) ? rvid_pkg::K_BCLR
                                    : ((f3 == 5) ? rvid_pkg::K_BEXT : rvid_pkg::K_UNK);
            7'h34: return (f3 == 1) ? rvid_pkg::K_BINV : rvid_pkg::K_UNK;
            7'h14: return (f3 == 1) ? rvid_pkg::K_BSET : rvid_pkg::K_UNK;
            default: return rvid_pkg::K_UNK;
        endcase
    endfunction

    // Decode of a full 32-bit word.
    function automatic t_decode decode_full(input logic [31:0] w, input logic [31:0] pc);
        t_decode d;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [4:0]  rd, r1, r2;
        logic [31:0] i12, im;
        rvid_pkg::t_op o;
        d  = '0;
        f3 = w[14:12];
        f7 = w[31:25];
        rd = w[11:7];
        r1 = w[19:15];
        r2 = w[24:20];
        i12 = sext({20'h0, w[31:20]}, 12);
        o  = rvid_pkg::K_UNK;
        case (w[6:0])
            rvid_pkg::OPC_LUI, rvid_pkg::OPC_AUIPC: begin
                d.op  = (w[6:0] == rvid_pkg::OPC_LUI) ? rvid_pkg::K_LUI : rvid_pkg::K_AUIPC;
                d.rd  = rd;
                d.imm = {w[31:12], 12'h0};
            end
            rvid_pkg::OPC_JAL: begin
                im = sext({11'h0, w[31], w[19:12], w[20], w[30:21], 1'b0}, 21);
                d.op = rvid_pkg::K_JAL; d.rd = rd; d.imm = im; d.tgt = pc + im;
            end
            rvid_pkg::OPC_JALR: begin
                d.op = rvid_pkg::K_JALR; d.rd = rd; d.rs1 = r1; d.imm = i12;
            end
            rvid_pkg::OPC_BRANCH: begin
                case (f3)
                    3'd0: o = rvid_pkg::K_BEQ;
                    3'd1: o = rvid_pkg::K_BNE;
                    3'd4: o = rvid_pkg::K_BLT;
                    3'd5: o = rvid_pkg::K_BGE;
                    3'd6: o = rvid_pkg::K_BLTU;
                    3'd7: o = rvid_pkg::K_BGEU;
                    default: o = rvid_pkg::K_UNK;
                endcase
                if (o != rvid_pkg::K_UNK) begin
                    im = sext({19'h0, w[31], w[7], w[30:25], w[11:8], 1'b0}, 13);
                    d.op = o; d.rs1 = r1; d.rs2 = r2; d.imm = im; d.tgt = pc + im;
                end
            end
            rvid_pkg::OPC_LOAD: begin
                case (f3)
                    3'd0: o = rvid_pkg::K_LB;
                    3'd1: o = rvid_pkg::K_LH;
                    3'd2: o = rvid_pkg::K_LW;
                    3'd4: o = rvid_pkg::K_LBU;
                    3'd5: o = rvid_pkg::K_LHU;
                    default: o = rvid_pkg::K_UNK;
                endcase
                if (o != rvid_pkg::K_UNK) begin
                    d.op = o; d.rd = rd; d.rs1 = r1; d.imm = i12;
                end
            end
            rvid_pkg::OPC_STORE: begin
                case (f3)
                    3'd0: o = rvid_pkg::K_SB;
                    3'd1: o = rvid_pkg::K_SH;
                    3'd2: o = rvid_pkg::K_SW;
                    default: o = rvid_pkg::K_UNK;
                endcase
                if (o != rvid_pkg::K_UNK) begin
                    d.op = o; d.rs1 = r1; d.rs2 = r2;
                    d.imm = sext({20'h0, w[31:25], w[11:7]}, 12);
                end
            end
            rvid_pkg::OPC_OPIMM: begin
                im = i12;
                case (f3)
                    3'd0: o = rvid_pkg::K_ADDI;
                    3'd2: o = rvid_pkg::K_SLTI;
                    3'd3: o = rvid_pkg::K_SLTIU;
                    3'd4: o = rvid_pkg::K_XORI;
                    3'd6: o = rvid_pkg::K_ORI;
                    3'd7: o = rvid_pkg::K_ANDI;
                    3'd1: begin
                        im = {27'h0, r2};
                        if (f7 == 7'h00) o = rvid_pkg::K_SLLI;
                        else if (f7 == 7'h30) begin
                            im = '0;
                            case (r2)
                                5'd0: o = rvid_pkg::K_CLZ;
                                5'd1: o = rvid_pkg::K_CTZ;
                                5'd2: o = rvid_pkg::K_CPOP;
                                5'd4: o = rvid_pkg::K_SEXTB;
                                5'd5: o = rvid_pkg::K_SEXTH;
                                default: o = rvid_pkg::K_UNK;
                            endcase
                        end
                        else if (f7 == 7'h24) o = rvid_pkg::K_BCLRI;
                        else if (f7 == 7'h34) o = rvid_pkg::K_BINVI;
                        else if (f7 == 7'h14) o = rvid_pkg::K_BSETI;
                    end
                    default: begin
                        im = {27'h0, r2};
                        if (f7 == 7'h00) o = rvid_pkg::K_SRLI;
                        else if (f7 == 7'h20) o = rvid_pkg::K_SRAI;
                        else if (f7 == 7'h30) o = rvid_pkg::K_RORI;
                        else if (f7 == 7'h24) o = rvid_pkg::K_BEXTI;
                        else if (f7 == 7'h14 && r2 == 5'd7) begin
                            o = rvid_pkg::K_ORCB; im = '0;
                        end
                        else if (f7 == 7'h34 && r2 == 5'h18) begin
                            o = rvid_pkg::K_REV8; im = '0;
                        end
                    end
                endcase
                if (o != rvid_pkg::K_UNK) begin
                    d.op = o; d.rd = rd; d.rs1 = r1; d.imm = im;
                end
            end
            rvid_pkg::OPC_OP: begin
                o = reg_op(f7, f3, r2);
                if (o != rvid_pkg::K_UNK) begin
                    d.op = o; d.rd = rd; d.rs1 = r1; d.rs2 = r2;
                end
            end
            rvid_pkg::OPC_FENCE: begin
                if (f3 == 0) d.op = rvid_pkg::K_FENCE;
                else if (f3 == 1) d.op = rvid_pkg::K_FENCEI;
            end
            rvid_pkg::OPC_SYSTEM: begin
                if (f3 == 0) begin
                    case (w[31:20])
                        rvid_pkg::SYS_ECALL:  d.op = rvid_pkg::K_ECALL;
                        rvid_pkg::SYS_EBREAK: d.op = rvid_pkg::K_EBREAK;
                        rvid_pkg::SYS_WFI:    d.op = rvid_pkg::K_WFI;
                        rvid_pkg::SYS_MRET:   d.op = rvid_pkg::K_MRET;
                        rvid_pkg::SYS_SRET:   d.op = rvid_pkg::K_SRET;
                        rvid_pkg::SYS_URET:   d.op = rvid_pkg::K_URET;
                        default:              d.op = rvid_pkg::K_UNK;
                    endcase
                end else if (f3 != 4) begin
                    case (f3)
                        3'd1: d.op = rvid_pkg::K_CSRRW;
                        3'd2: d.op = rvid_pkg::K_CSRRS;
                        3'd3: d.op = rvid_pkg::K_CSRRC;
                        3'd5: d.op = rvid_pkg::K_CSRRWI;
                        3'd6: d.op = rvid_pkg::K_CSRRSI;
                        default: d.op = rvid_pkg::K_CSRRCI;
                    endcase
                    d.rd = rd; d.rs1 = r1; d.csr = w[31:20];
                end
            end
            rvid_pkg::OPC_AMO: begin
                if (f3 == 2 || f3 == 3) begin
                    case (w[31:27])
                        5'h00: o = rvid_pkg::K_AMOADD;
                        5'h01: o = rvid_pkg::K_AMOSWAP;
                        5'h02: o = rvid_pkg::K_LR;
                        5'h03: o = rvid_pkg::K_SC;
                        5'h04: o = rvid_pkg::K_AMOXOR;
                        5'h08: o = rvid_pkg::K_AMOOR;
                        5'h0C: o = rvid_pkg::K_AMOAND;
                        5'h10: o = rvid_pkg::K_AMOMIN;
                        5'h14: o = rvid_pkg::K_AMOMAX;
                        5'h18: o = rvid_pkg::K_AMOMINU;
                        5'h1C: o = rvid_pkg::K_AMOMAXU;
                        default: o = rvid_pkg::K_UNK;
                    endcase
                    if (o != rvid_pkg::K_UNK) begin
                        d.op = o; d.rd = rd; d.rs1 = r1;
                        d.rs2 = (o == rvid_pkg::K_LR) ? 5'd0 : r2;
                        d.aq = w[26]; d.rl = w[25]; d.dw = (f3 == 3);
                    end
                end
            end
            default: ;
        endcase
        return d;
    endfunction

    // Decode of a 16-bit compressed word.
    function automatic t_decode decode_short(input logic [15:0] h, input logic [31:0] pc);
        t_decode d;
        logic [2:0]  f3;
        logic [4:0]  r5, s5, ph, pl;
        logic [31:0] c6, u6, jo, bo, wo, v;
        d  = '0;
        d.comp = 1'b1;
        f3 = h[15:13];
        r5 = h[11:7];
        s5 = h[6:2];
        ph = {2'b01, h[9:7]};
        pl = {2'b01, h[4:2]};
        u6 = {26'h0, h[12], h[6:2]};
        c6 = sext(u6, 6);
        jo = sext({20'h0, h[12], h[8], h[10:9], h[6], h[7], h[2], h[11], h[5:3], 1'b0}, 12);
        bo = sext({23'h0, h[12], h[6:5], h[2], h[11:10], h[4:3], 1'b0}, 9);
        wo = {25'h0, h[5], h[12:10], h[6], 2'b00};
        case (h[1:0])
            2'b00: begin
                case (f3)
                    3'd0: begin
                        v = {22'h0, h[10:7], h[12:11], h[5], h[6], 2'b00};
                        if (v == 0) d.op = rvid_pkg::K_ILL;
                        else begin
                            d.op = rvid_pkg::K_CADDI4SPN; d.rd = pl; d.rs1 = 5'd2; d.imm = v;
                        end
                    end
                    3'd1: d.op = rvid_pkg::K_CFLD;
                    3'd2: begin
                        d.op = rvid_pkg::K_CLW; d.rd = pl; d.rs1 = ph; d.imm = wo;
                    end
                    3'd3: d.op = rvid_pkg::K_CFLW;
                    3'd5: d.op = rvid_pkg::K_CFSD;
                    3'd6: begin
                        d.op = rvid_pkg::K_CSW; d.rs2 = pl; d.rs1 = ph; d.imm = wo;
                    end
                    3'd7: d.op = rvid_pkg::K_CFSW;
                    default: ;
                endcase
            end
            2'b01: begin
                case (f3)
                    3'd0: begin
                        if (r5 == 0) d.op = (c6 == 0) ? rvid_pkg::K_CNOP : rvid_pkg::K_ILL;
                        else begin
                            d.op = rvid_pkg::K_CADDI; d.rd = r5; d.rs1 = r5; d.imm = c6;
                        end
                    end
                    3'd1: begin
                        d.op = rvid_pkg::K_CJAL; d.rd = 5'd1; d.imm = jo; d.tgt = pc + jo;
                    end
                    3'd2: begin
                        if (r5 == 0) d.op = rvid_pkg::K_ILL;
                        else begin
                            d.op = rvid_pkg::K_CLI; d.rd = r5; d.imm = c6;
                        end
                    end
                    3'd3: begin
                        if (r5 == 5'd2) begin
                            v = sext({22'h0, h[12], h[4:3], h[5], h[2], h[6], 4'h0}, 10);
                            if (v == 0) d.op = rvid_pkg::K_ILL;
                            else begin
                                d.op = rvid_pkg::K_CADDI16SP; d.rd = 5'd2; d.rs1 = 5'd2;
                                d.imm = v;
                            end
                        end else if (r5 == 0 || c6 == 0) d.op = rvid_pkg::K_ILL;
                        else begin
                            d.op = rvid_pkg::K_CLUI; d.rd = r5; d.imm = c6 << 12;
                        end
                    end
                    3'd4: begin
                        if (h[11:10] == 2'b11) begin
                            if (!h[12]) begin
                                d.op = rvid_pkg::t_op'(rvid_pkg::K_CSUB + h[6:5]); d.rs2 = pl;
                                d.rd = ph; d.rs1 = ph;
                            end
                        end else begin
                            d.op  = rvid_pkg::t_op'(rvid_pkg::K_CSRLI + h[11:10]);
                            d.imm = (h[11:10] == 2'b10) ? c6 : u6;
                            d.rd  = ph; d.rs1 = ph;
                        end
                    end
                    3'd5: begin
                        d.op = rvid_pkg::K_CJ; d.imm = jo; d.tgt = pc + jo;
                    end
                    default: begin
                        d.op = (f3 == 3'd6) ? rvid_pkg::K_CBEQZ : rvid_pkg::K_CBNEZ;
                        d.rs1 = ph; d.imm = bo; d.tgt = pc + bo;
                    end
                endcase
            end
            default: begin
                case (f3)
                    3'd0: begin
                        if (r5 == 0 || u6 == 0) d.op = rvid_pkg::K_ILL;
                        else begin
                            d.op = rvid_pkg::K_CSLLI; d.rd = r5; d.rs1 = r5; d.imm = u6;
                        end
                    end
                    3'd1: d.op = rvid_pkg::K_CFLDSP;
                    3'd2: begin
                        if (r5 == 0) d.op = rvid_pkg::K_ILL;
                        else begin
                            d.op = rvid_pkg::K_CLWSP; d.rd = r5; d.rs1 = 5'd2;
                            d.imm = {24'h0, h[3:2], h[12], h[6:4], 2'b00};
                        end
                    end
                    3'd3: d.op = rvid_pkg::K_CFLWSP;
                    3'd4: begin
                        if (!h[12]) begin
                            if (s5 == 0) begin
                                if (r5 == 0) d.op = rvid_pkg::K_ILL;
                                else begin
                                    d.op = rvid_pkg::K_CJR; d.rs1 = r5;
                                end
                            end else begin
                                d.op = rvid_pkg::K_CMV; d.rd = r5; d.rs2 = s5;
                            end
                        end else if (r5 == 0 && s5 == 0) d.op = rvid_pkg::K_CEBREAK;
                        else if (s5 == 0) begin
                            d.op = rvid_pkg::K_CJALR; d.rd = 5'd1; d.rs1 = r5;
                        end else begin
                            d.op = rvid_pkg::K_CADD; d.rd = r5; d.rs1 = r5; d.rs2 = s5;
                        end
                    end
                    3'd5: d.op = rvid_pkg::K_CFSDSP;
                    3'd6: begin
                        d.op = rvid_pkg::K_CSWSP; d.rs2 = s5; d.rs1 = 5'd2;
                        d.imm = {24'h0, h[8:7], h[12:9], 2'b00};
                    end
                    default: d.op = rvid_pkg::K_CFSWSP;
                endcase
            end
        endcase
        return d;
    endfunction

    function automatic t_decode decode_instr(input logic [31:0] w, input logic [31:0] pc);
        if (w[1:0] != 2'b11) return decode_short(w[15:0], pc);
        return decode_full(w, pc);
    endfunction

    // Sends one item after a random gap and records its expected decode.
    // With a zero gap the next item follows in the very next cycle.
    task automatic send_instr(input logic [31:0] w, input logic [31:0] pc);
        int gap;
        gap = $urandom_range(0, 4);
        if (($urandom & 3) == 0) gap = 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_instr_word <= w;
        i_pc         <= pc;
        decode_queue.push_back(decode_instr(w, pc));
        if (w[1:0] != 2'b11) compressed_sent++;
        do @(posedge i_clk); while (o_stall);
        sent_count++;
    endtask

    // The stall that the result side applies before each result.
    initial begin : stall_driver
        int hold;
        i_stall = 1'b1;
        forever begin
            @(negedge i_clk);
            if (o_valid && !i_stall) begin
                hold = $urandom_range(0, 4);
                if (($urandom & 3) == 0) hold = 0;
                i_stall <= (hold != 0);
                while (hold > 0) begin
                    @(negedge i_clk);
                    hold--;
                    if (hold == 0) i_stall <= 1'b0;
                end
            end else if (i_rst_n) begin
                i_stall <= 1'b0;
            end
        end
    end

    // Compares each accepted result with the oldest pending decode.
    always @(posedge i_clk) begin : result_check
        t_decode got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_op_id, o_is_compressed, o_rd, o_rs1, o_rs2, o_imm, o_csr_addr,
                   o_target, o_acquire, o_release_res, o_double_width};
            if (decode_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                error_count++;
            end else begin
                want = decode_queue.pop_front();
                checked_count++;
                if (got.op !== want.op) begin
                    $display("%0t: op_id exp %0d got %0d", $time, want.op, got.op);
                    error_count++;
                end
                if (got.comp !== want.comp) begin
                    $display("%0t: is_compressed exp %0d got %0d", $time, want.comp, got.comp);
                    error_count++;
                end
                if (got.rd !== want.rd) begin
                    $display("%0t: rd exp %0d got %0d", $time, want.rd, got.rd);
                    error_count++;
                end
                if (got.rs1 !== want.rs1) begin
                    $display("%0t: rs1 exp %0d got %0d", $time, want.rs1, got.rs1);
                    error_count++;
                end
                if (got.rs2 !== want.rs2) begin
                    $display("%0t: rs2 exp %0d got %0d", $time, want.rs2, got.rs2);
                    error_count++;
                end
                if (got.imm !== want.imm) begin
                    $display("%0t: imm exp %h got %h", $time, want.imm, got.imm);
                    error_count++;
                end
                if (got.csr !== want.csr) begin
                    $display("%0t: csr_addr exp %h got %h", $time, want.csr, got.csr);
                    error_count++;
                end
                if (got.tgt !== want.tgt) begin
                    $display("%0t: target exp %h got %h", $time, want.tgt, got.tgt);
                    error_count++;
                end
                if (got.aq !== want.aq) begin
                    $display("%0t: acquire exp %0d got %0d", $time, want.aq, got.aq);
                    error_count++;
                end
                if (got.rl !== want.rl) begin
                    $display("%0t: release_res exp %0d got %0d", $time, want.rl, got.rl);
                    error_count++;
                end
                if (got.dw !== want.dw) begin
                    $display("%0t: double_width exp %0d got %0d", $time, want.dw, got.dw);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: cycles without any accepted item on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCH_MAX) begin
            $display("%0t: watchdog expired", $time);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Drops valid after the last item and waits until every result has come.
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (decode_queue.size() != 0) @(posedge i_clk);
    endtask

    // Directed corners: lui, jal, branch, op-imm, op and amo words, system forms and reserved compressed forms.
    task automatic test_directed();
        send_instr(32'h0000_0000, 32'h0);            // all-zero compressed illegal
        send_instr(32'hFFFF_FFFF, 32'hFFFF_FFFF);    // all-ones word
        send_instr(32'hFFFF_F0B7, 32'h1000);         // lui with full upper value
        send_instr(32'h8000_006F, 32'h0000_0010);    // jal with most negative offset
        send_instr(32'h7FFF_F0EF, 32'hFFFF_FFF0);    // jal, target wraps
        send_instr(32'h8000_0063, 32'h0000_0100);    // beq negative
        send_instr(32'h0000_0073, 32'h0);            // ecall
        send_instr(32'h0010_0073, 32'h0);            // ebreak
        send_instr(32'h1050_0073, 32'h0);            // wfi
        send_instr(32'h3020_0073, 32'h0);            // mret
        send_instr(32'h1020_0073, 32'h0);            // sret
        send_instr(32'h0020_0073, 32'h0);            // uret
        send_instr(32'hFFFF_F073, 32'h0);            // csrrci, all ones
        send_instr(32'h0600_A5AF, 32'h0);            // amoadd.w aq rl
        send_instr(32'h1000_B52F, 32'h0);            // lr.d
        send_instr(32'h6985_5513, 32'h0);            // rev8
        send_instr(32'h0805_4533, 32'h0);            // zext.h
        send_instr(32'h0000_0001, 32'h0);            // c.nop
        send_instr(32'h0000_1001, 32'h0);            // c.addi x0 nonzero: illegal
        send_instr(32'h0000_6101, 32'h0);            // c.addi16sp zero: illegal
        send_instr(32'h0000_6081, 32'h0);            // c.lui zero imm: illegal
        send_instr(32'h0000_9002, 32'h0);            // c.ebreak
        send_instr(32'h0000_8002, 32'h0);            // c.jr x0: illegal
        send_instr(32'h0000_A009, 32'hFFFF_FFFE);    // c.j wraps
        send_instr(32'hFFFF_9C21, 32'h0);            // reserved compressed slot, high half set
    endtask

    // Random part: real opcodes with random fields, compressed words and some raw noise.
    task automatic test_random();
        logic [6:0]  opcodes [12];
        logic [31:0] w;
        int          sel;
        opcodes = '{rvid_pkg::OPC_LUI, rvid_pkg::OPC_AUIPC, rvid_pkg::OPC_JAL,
                    rvid_pkg::OPC_JALR, rvid_pkg::OPC_BRANCH, rvid_pkg::OPC_LOAD,
                    rvid_pkg::OPC_STORE, rvid_pkg::OPC_OPIMM, rvid_pkg::OPC_OP,
                    rvid_pkg::OPC_FENCE, rvid_pkg::OPC_SYSTEM, rvid_pkg::OPC_AMO};
        for (int n = 0; n < RAND_ITEMS; n++) begin
            w   = $urandom;
            sel = $urandom_range(0, 9);
            if (sel < 4) begin
                w[6:0] = opcodes[$urandom_range(0, 11)];
                if (($urandom & 1) &&
                    (w[6:0] == rvid_pkg::OPC_OP || w[6:0] == rvid_pkg::OPC_OPIMM)) begin
                    case ($urandom_range(0, 7))
                        0: w[31:25] = 7'h00;
                        1: w[31:25] = 7'h01;
                        2: w[31:25] = 7'h20;
                        3: w[31:25] = 7'h05;
                        4: w[31:25] = 7'h04;
                        5: w[31:25] = 7'h30;
                        6: w[31:25] = 7'h10;
                        default: w[31:25] = {2'b01, 5'($urandom_range(0, 31)) & 5'h14};
                    endcase
                    if ($urandom & 1) w[24:20] = 5'($urandom_range(0, 7));
                end
            end else if (sel < 8) begin
                if (w[1:0] == 2'b11) w[1:0] = 2'($urandom_range(0, 2));
                if (($urandom & 3) == 0) w[11:7] = 5'($urandom_range(0, 2));
                if (($urandom & 3) == 0) w[6:2] = 5'd0;
            end
            send_instr(w, $urandom);
            if (n == RAND_ITEMS / 2) wait_drained();
        end
    endtask

    initial begin
        error_count     = 0;
        sent_count      = 0;
        checked_count   = 0;
        compressed_sent = 0;
        idle_cycles     = 0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_instr_word    = '0;
        i_pc            = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        wait_drained();
        test_random();
        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d items (%0d compressed), checked %0d decodes.",
                 sent_count, compressed_sent, checked_count);
        $display("Covered directed opcode corners and random full and compressed words.");
        if (error_count == 0 && decode_queue.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
